>>> src/incremental_pid_speed_loop_macros.svh
// Assertion macros for the incremental PID speed loop checker
`ifndef INCREMENTAL_PID_SPEED_LOOP_MACROS_SVH
`define INCREMENTAL_PID_SPEED_LOOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define IPSL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define IPSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ipsl_pkg.sv
// Types and constants shared by the incremental PID speed loop modules
package ipsl_pkg;

    localparam int TGT_W      = 16;
    localparam int CNT_W      = 16;
    localparam int ERR_W      = 18;
    localparam int DE_W       = ERR_W + 1;
    localparam int D2E_W      = ERR_W + 2;
    localparam int GAIN_W     = 10;
    localparam int BAND_W     = 10;
    localparam int LIM_W      = 14;
    localparam int DRV_W      = 15;
    localparam int DUTY_W     = 14;
    localparam int PP_W       = GAIN_W + 1 + DE_W;
    localparam int PI_W       = GAIN_W + 1 + ERR_W;
    localparam int PD_W       = GAIN_W + 1 + D2E_W;
    localparam int SUM_W      = PD_W + 2;
    localparam int ACC_W      = SUM_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [GAIN_W-1:0] GAIN_P_RST = 10'd160;
    localparam logic [GAIN_W-1:0] GAIN_I_RST = 10'd80;
    localparam logic [GAIN_W-1:0] GAIN_D_RST = 10'd40;
    localparam logic [BAND_W-1:0] BAND_RST   = 10'd30;
    localparam logic [LIM_W-1:0]  LIMIT_RST  = 14'd9500;

    localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P = 3'd0,
        CFG_GAIN_I = 3'd1,
        CFG_GAIN_D = 3'd2,
        CFG_BAND   = 3'd3,
        CFG_LIMIT  = 3'd4,
        CFG_MIRROR = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [BAND_W-1:0] error_band;
        logic [LIM_W-1:0]  drive_limit;
        logic              mirror_side;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] e0;
        logic signed [DE_W-1:0]  de;
        logic signed [D2E_W-1:0] d2e;
        logic                    above;
        logic                    below;
    } diff_beat_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    above;
        logic                    below;
    } sum_beat_t;

endpackage

>>> src/incremental_pid_speed_loop.sv
// Incremental PID speed loop with bang-bang band: top level
//
// One input beat is one control period: target speed, encoder pulse count and
// encoder direction level, taken on s_valid && s_ready. One result beat leaves
// on m_valid && m_ready: the signed saturated drive and the two H-bridge duties.
// Gains, band, drive limit and side are written on the cfg_ channel (always
// ready, index 0..5, other indexes ignored); the user must write them only
// while no beat is in flight, which the block itself does not enforce.
// The result passes through the input register, error/history stage,
// difference stage, multiplier stage, sum stage and the drive/output register.
// Throughput: one beat per cycle while m_ready is high. The drive accumulator
// closes its loop in the output stage, so consecutive beats need no spacing.
// A stalled receiver holds the result in the output register; each stage keeps
// taking beats while the one after it has room, so up to six beats sit in the
// pipe before s_ready drops.
// Reset clears the error history and the stored drive to zero, loads the
// default register values and empties the pipe.
module incremental_pid_speed_loop #(
    parameter int COUNT_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ipsl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ipsl_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [ipsl_pkg::TGT_W-1:0]  s_target_speed,
    input  logic [ipsl_pkg::CNT_W-1:0]         s_pulse_count,
    input  logic                               s_direction_level,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ipsl_pkg::DRV_W-1:0]  m_drive,
    output logic [ipsl_pkg::DUTY_W-1:0]        m_channel_a_duty,
    output logic [ipsl_pkg::DUTY_W-1:0]        m_channel_b_duty
);
    import ipsl_pkg::*;

    cfg_t        cfg;
    logic        diff_valid;
    logic        diff_ready;
    diff_beat_t  diff_beat;
    logic        sum_valid;
    logic        sum_ready;
    sum_beat_t   sum_beat;

    ipsl_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ipsl_err #(
        .COUNT_BITS (COUNT_BITS)
    ) u_err (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_target_speed    (s_target_speed),
        .s_pulse_count     (s_pulse_count),
        .s_direction_level (s_direction_level),
        .diff_valid        (diff_valid),
        .diff_ready        (diff_ready),
        .diff_beat         (diff_beat)
    );

    ipsl_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .diff_valid (diff_valid),
        .diff_ready (diff_ready),
        .diff_beat  (diff_beat),
        .sum_valid  (sum_valid),
        .sum_ready  (sum_ready),
        .sum_beat   (sum_beat)
    );

    ipsl_out u_out (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .sum_valid        (sum_valid),
        .sum_ready        (sum_ready),
        .sum_beat         (sum_beat),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_drive          (m_drive),
        .m_channel_a_duty (m_channel_a_duty),
        .m_channel_b_duty (m_channel_b_duty)
    );

endmodule

>>> src/ipsl_cfg.sv
// Configuration register bank for the speed loop
module ipsl_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ipsl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ipsl_pkg::CFG_DATA_W-1:0]    cfg_data,
    output ipsl_pkg::cfg_t                     cfg
);
    import ipsl_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p      <= GAIN_P_RST;
            cfg_reg.gain_i      <= GAIN_I_RST;
            cfg_reg.gain_d      <= GAIN_D_RST;
            cfg_reg.error_band  <= BAND_RST;
            cfg_reg.drive_limit <= LIMIT_RST;
            cfg_reg.mirror_side <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GAIN_P: cfg_reg.gain_p      <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_I: cfg_reg.gain_i      <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D: cfg_reg.gain_d      <= cfg_data[GAIN_W-1:0];
                CFG_BAND:   cfg_reg.error_band  <= cfg_data[BAND_W-1:0];
                CFG_LIMIT:  cfg_reg.drive_limit <= cfg_data[LIM_W-1:0];
                CFG_MIRROR: cfg_reg.mirror_side <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

>>> src/ipsl_err.sv
// Input register, speed error with history shift, and error differences
module ipsl_err #(
    parameter int COUNT_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ipsl_pkg::cfg_t                     cfg,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [ipsl_pkg::TGT_W-1:0]  s_target_speed,
    input  logic [ipsl_pkg::CNT_W-1:0]         s_pulse_count,
    input  logic                               s_direction_level,
    output logic                               diff_valid,
    input  logic                               diff_ready,
    output ipsl_pkg::diff_beat_t               diff_beat
);
    import ipsl_pkg::*;

    localparam int CNT_USE = (COUNT_BITS < CNT_W) ? COUNT_BITS : CNT_W;
    localparam logic [CNT_W-1:0] CNT_MASK =
        CNT_W'(((CNT_W+1)'(1) << CNT_USE) - (CNT_W+1)'(1));

    logic                      in_vld_reg;
    logic signed [TGT_W-1:0]   tgt_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      dir_reg;
    logic                      err_vld_reg;
    logic signed [ERR_W-1:0]   hist_reg [3];
    logic                      diff_vld_reg;
    diff_beat_t                diff_reg;

    logic                      diff_ld_ok;
    logic                      err_ready;
    logic signed [TGT_W:0]     tgt_ext;
    logic signed [CNT_W:0]     spd_ext;
    logic signed [CNT_W+1:0]   err_wide;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [ERR_W-1:0]   band_pos;
    logic signed [ERR_W-1:0]   band_neg;
    diff_beat_t                diff_next;

    assign diff_ld_ok = !diff_vld_reg || diff_ready;
    assign err_ready  = !err_vld_reg || diff_ld_ok;
    assign s_ready    = !in_vld_reg || err_ready;

    always_comb begin
        tgt_ext = (TGT_W+1)'(tgt_reg);
        if (cfg.mirror_side) begin
            tgt_ext = -tgt_ext;
        end
        spd_ext = $signed({1'b0, cnt_reg & CNT_MASK});
        if (dir_reg) begin
            spd_ext = -spd_ext;
        end
        err_wide = (CNT_W+2)'(tgt_ext) - (CNT_W+2)'(spd_ext);
        priority if (err_wide > (CNT_W+2)'(ERR_MAX)) begin
            err_next = ERR_MAX;
        end else if (err_wide < (CNT_W+2)'(ERR_MIN)) begin
            err_next = ERR_MIN;
        end else begin
            err_next = ERR_W'(err_wide);
        end
    end

    always_comb begin
        band_pos        = $signed(ERR_W'(cfg.error_band));
        band_neg        = -band_pos;
        diff_next.e0    = hist_reg[0];
        diff_next.de    = DE_W'(hist_reg[0]) - DE_W'(hist_reg[1]);
        diff_next.d2e   = D2E_W'(hist_reg[0]) - (D2E_W'(hist_reg[1]) <<< 1)
                        + D2E_W'(hist_reg[2]);
        diff_next.above = hist_reg[0] > band_pos;
        diff_next.below = hist_reg[0] < band_neg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            err_vld_reg  <= 1'b0;
            diff_vld_reg <= 1'b0;
            hist_reg[0]  <= '0;
            hist_reg[1]  <= '0;
            hist_reg[2]  <= '0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (err_ready) begin
                err_vld_reg <= in_vld_reg;
            end
            if (diff_ld_ok) begin
                diff_vld_reg <= err_vld_reg;
            end
            if (in_vld_reg && err_ready) begin
                hist_reg[2] <= hist_reg[1];
                hist_reg[1] <= hist_reg[0];
                hist_reg[0] <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            tgt_reg <= s_target_speed;
            cnt_reg <= s_pulse_count;
            dir_reg <= s_direction_level;
        end
        if (err_vld_reg && diff_ld_ok) begin
            diff_reg <= diff_next;
        end
    end

    assign diff_valid = diff_vld_reg;
    assign diff_beat  = diff_reg;

endmodule

>>> src/ipsl_mac.sv
// Gain products and their sum for the velocity-form increment
module ipsl_mac (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ipsl_pkg::cfg_t        cfg,
    input  logic                  diff_valid,
    output logic                  diff_ready,
    input  ipsl_pkg::diff_beat_t  diff_beat,
    output logic                  sum_valid,
    input  logic                  sum_ready,
    output ipsl_pkg::sum_beat_t   sum_beat
);
    import ipsl_pkg::*;

    logic                    prod_vld_reg;
    logic signed [PP_W-1:0]  pp_reg;
    logic signed [PI_W-1:0]  pi_reg;
    logic signed [PD_W-1:0]  pd_reg;
    logic                    above_reg;
    logic                    below_reg;
    logic                    sum_vld_reg;
    sum_beat_t               sum_reg;

    logic                    sum_ld_ok;
    sum_beat_t               sum_next;

    assign sum_ld_ok  = !sum_vld_reg || sum_ready;
    assign diff_ready = !prod_vld_reg || sum_ld_ok;

    always_comb begin
        sum_next.sum   = SUM_W'(pp_reg) + SUM_W'(pi_reg) + SUM_W'(pd_reg);
        sum_next.above = above_reg;
        sum_next.below = below_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
        end else begin
            if (diff_ready) begin
                prod_vld_reg <= diff_valid;
            end
            if (sum_ld_ok) begin
                sum_vld_reg <= prod_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (diff_valid && diff_ready) begin
            pp_reg    <= PP_W'($signed({1'b0, cfg.gain_p})) * PP_W'(diff_beat.de);
            pi_reg    <= PI_W'($signed({1'b0, cfg.gain_i})) * PI_W'(diff_beat.e0);
            pd_reg    <= PD_W'($signed({1'b0, cfg.gain_d})) * PD_W'(diff_beat.d2e);
            above_reg <= diff_beat.above;
            below_reg <= diff_beat.below;
        end
        if (prod_vld_reg && sum_ld_ok) begin
            sum_reg <= sum_next;
        end
    end

    assign sum_valid = sum_vld_reg;
    assign sum_beat  = sum_reg;

endmodule

>>> src/ipsl_out.sv
// Drive accumulation, bang-bang override, saturation and bridge duty split
module ipsl_out (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ipsl_pkg::cfg_t                      cfg,
    input  logic                                sum_valid,
    output logic                                sum_ready,
    input  ipsl_pkg::sum_beat_t                 sum_beat,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ipsl_pkg::DRV_W-1:0]   m_drive,
    output logic [ipsl_pkg::DUTY_W-1:0]         m_channel_a_duty,
    output logic [ipsl_pkg::DUTY_W-1:0]         m_channel_b_duty
);
    import ipsl_pkg::*;

    logic                     m_valid_reg;
    logic signed [DRV_W-1:0]  drive_reg;
    logic [DUTY_W-1:0]        duty_a_reg;
    logic [DUTY_W-1:0]        duty_b_reg;

    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  lim_pos;
    logic signed [ACC_W-1:0]  lim_neg;
    logic signed [ACC_W-1:0]  drive_sel;
    logic signed [DRV_W-1:0]  drive_next;
    logic signed [DRV_W-1:0]  drive_neg;
    logic [DUTY_W-1:0]        pos_mag;
    logic [DUTY_W-1:0]        neg_mag;

    assign sum_ready = !m_valid_reg || m_ready;

    always_comb begin
        acc     = ACC_W'(drive_reg) + ACC_W'(sum_beat.sum);
        lim_pos = $signed(ACC_W'(cfg.drive_limit));
        lim_neg = -lim_pos;
        priority if (sum_beat.above) begin
            drive_sel = lim_pos;
        end else if (sum_beat.below) begin
            drive_sel = lim_neg;
        end else if (acc > lim_pos) begin
            drive_sel = lim_pos;
        end else if (acc < lim_neg) begin
            drive_sel = lim_neg;
        end else begin
            drive_sel = acc;
        end
        drive_next = DRV_W'(drive_sel);
        drive_neg  = -drive_next;
        pos_mag    = (drive_next > 0) ? drive_next[DUTY_W-1:0] : '0;
        neg_mag    = (drive_next < 0) ? drive_neg[DUTY_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            drive_reg   <= '0;
        end else begin
            if (sum_ready) begin
                m_valid_reg <= sum_valid;
            end
            if (sum_valid && sum_ready) begin
                drive_reg <= drive_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_valid && sum_ready) begin
            duty_a_reg <= cfg.mirror_side ? neg_mag : pos_mag;
            duty_b_reg <= cfg.mirror_side ? pos_mag : neg_mag;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_drive          = drive_reg;
    assign m_channel_a_duty = duty_a_reg;
    assign m_channel_b_duty = duty_b_reg;

endmodule

>>> src/ipsl_chk.sv
// Port-level checker for the speed loop result channel, with its bind
`include "incremental_pid_speed_loop_macros.svh"

module ipsl_chk (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic signed [ipsl_pkg::DRV_W-1:0]  m_drive,
    input  logic [ipsl_pkg::DUTY_W-1:0]        m_channel_a_duty,
    input  logic [ipsl_pkg::DUTY_W-1:0]        m_channel_b_duty
);
    import ipsl_pkg::*;

    logic [DRV_W-1:0] duty_sum;
    logic [DRV_W-1:0] drive_mag;

    assign duty_sum  = DRV_W'(m_channel_a_duty) + DRV_W'(m_channel_b_duty);
    assign drive_mag = m_drive[DRV_W-1] ? DRV_W'(-m_drive) : DRV_W'(m_drive);

    `IPSL_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_drive) && $stable(m_channel_a_duty) && $stable(m_channel_b_duty), "result beat changed while stalled")
    `IPSL_ASSERT_IMP(a_duty_excl, aclk, aresetn, m_valid, m_channel_a_duty == '0 || m_channel_b_duty == '0, "both bridge channels driven")
    `IPSL_ASSERT_IMP(a_duty_mag, aclk, aresetn, m_valid, duty_sum == drive_mag, "duty does not match drive magnitude")
    `IPSL_ASSERT_IMP(a_zero_drive, aclk, aresetn, m_valid && m_drive == '0, m_channel_a_duty == '0 && m_channel_b_duty == '0, "duty on zero drive")

endmodule

bind incremental_pid_speed_loop ipsl_chk u_ipsl_chk (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_drive          (m_drive),
    .m_channel_a_duty (m_channel_a_duty),
    .m_channel_b_duty (m_channel_b_duty)
);

>>> sim/tb_incremental_pid_speed_loop.sv
// Self-checking testbench for the incremental PID speed loop with bang-bang band
`timescale 1ns / 100ps

module tb_incremental_pid_speed_loop;

    import ipsl_pkg::*;

    localparam int COUNT_BITS = 16;
    localparam int CNT_KEEP   = (COUNT_BITS < 16) ? COUNT_BITS : 16;
    localparam longint CNT_MASK   = (longint'(1) << CNT_KEEP) - 1;
    localparam longint ERR_TOP    = ERR_MAX;
    localparam longint ERR_BOTTOM = ERR_MIN;
    localparam int END_SLACK   = 20;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_GAP     = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [DRV_W-1:0] drive;
        logic [DUTY_W-1:0]       duty_a;
        logic [DUTY_W-1:0]       duty_b;
    } drive_beat_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [TGT_W-1:0]  s_target_speed = '0;
    logic [CNT_W-1:0]         s_pulse_count = '0;
    logic                     s_direction_level = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DRV_W-1:0]  m_drive;
    logic [DUTY_W-1:0]        m_channel_a_duty;
    logic [DUTY_W-1:0]        m_channel_b_duty;

    cfg_t settings = '{gain_p: GAIN_P_RST, gain_i: GAIN_I_RST, gain_d: GAIN_D_RST,
                       error_band: BAND_RST, drive_limit: LIMIT_RST, mirror_side: 1'b0};
    logic signed [ERR_W-1:0] err_hist [3] = '{default: '0};
    logic signed [DRV_W-1:0] drive_acc = '0;

    drive_beat_t pending_drives [$];
    int          mismatches = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          tx_held = 1'b0;
    int unsigned clk_count = 0;

    incremental_pid_speed_loop #(
        .COUNT_BITS (COUNT_BITS)
    ) i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_target_speed    (s_target_speed),
        .s_pulse_count     (s_pulse_count),
        .s_direction_level (s_direction_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_drive           (m_drive),
        .m_channel_a_duty  (m_channel_a_duty),
        .m_channel_b_duty  (m_channel_b_duty)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        clk_count <= clk_count + 1;
        if (clk_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic report_mismatch(input string what);
        if (mismatches < 40)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Drive update for one control period; advances the error history and stored drive
    function automatic drive_beat_t next_drive(input logic signed [TGT_W-1:0] tgt,
                                               input logic [CNT_W-1:0] cnt,
                                               input logic dir);
        longint t, spd, e0, e1, e2, d, lim, bnd, pos, neg;
        drive_beat_t res;
        t   = tgt;
        spd = longint'(cnt) & CNT_MASK;
        lim = settings.drive_limit;
        bnd = settings.error_band;
        if (dir)
            spd = -spd;
        if (settings.mirror_side)
            t = -t;
        e0 = t - spd;
        if (e0 > ERR_TOP)
            e0 = ERR_TOP;
        else if (e0 < ERR_BOTTOM)
            e0 = ERR_BOTTOM;
        err_hist[2] = err_hist[1];
        err_hist[1] = err_hist[0];
        err_hist[0] = e0[ERR_W-1:0];
        e1 = err_hist[1];
        e2 = err_hist[2];
        d = drive_acc;
        if (e0 > bnd) begin
            d = lim;
        end else if (e0 < -bnd) begin
            d = -lim;
        end else begin
            d += longint'(settings.gain_p) * (e0 - e1)
               + longint'(settings.gain_i) * e0
               + longint'(settings.gain_d) * (e0 - 2 * e1 + e2);
        end
        if (d > lim)
            d = lim;
        else if (d < -lim)
            d = -lim;
        drive_acc = d[DRV_W-1:0];
        pos = (d > 0) ? d : 0;
        neg = (d < 0) ? -d : 0;
        res.drive = d[DRV_W-1:0];
        if (settings.mirror_side) begin
            res.duty_a = neg[DUTY_W-1:0];
            res.duty_b = pos[DUTY_W-1:0];
        end else begin
            res.duty_a = pos[DUTY_W-1:0];
            res.duty_b = neg[DUTY_W-1:0];
        end
        return res;
    endfunction

    function automatic void latch_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GAIN_P: settings.gain_p      = data[GAIN_W-1:0];
            CFG_GAIN_I: settings.gain_i      = data[GAIN_W-1:0];
            CFG_GAIN_D: settings.gain_d      = data[GAIN_W-1:0];
            CFG_BAND:   settings.error_band  = data[BAND_W-1:0];
            CFG_LIMIT:  settings.drive_limit = data[LIM_W-1:0];
            CFG_MIRROR: settings.mirror_side = data[0];
            default: ;
        endcase
    endfunction

    function automatic int pick_level(input int top, input int typical);
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return 0;
        if (r < 24)
            return top;
        return $urandom_range(typical);
    endfunction

    always @(posedge aclk) begin : check_results
        drive_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_drives.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat, drive %0d", m_drive));
            end else begin
                want = pending_drives.pop_front();
                if (m_drive !== want.drive)
                    report_mismatch($sformatf("drive got %0d want %0d", m_drive, want.drive));
                if (m_channel_a_duty !== want.duty_a)
                    report_mismatch($sformatf("channel a duty got %0d want %0d",
                                              m_channel_a_duty, want.duty_a));
                if (m_channel_b_duty !== want.duty_b)
                    report_mismatch($sformatf("channel b duty got %0d want %0d",
                                              m_channel_b_duty, want.duty_b));
            end
        end
    end

    // Leaves s_valid high on return; the next call or stop_input follows in the same step
    task automatic send_period(input logic signed [TGT_W-1:0] tgt,
                               input logic [CNT_W-1:0] cnt,
                               input logic dir);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            if (tx_held)
                s_valid <= 1'b0;
            tx_held = 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_target_speed    <= tgt;
        s_pulse_count     <= cnt;
        s_direction_level <= dir;
        tx_held = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_drives.push_back(next_drive(tgt, cnt, dir));
    endtask

    task automatic stop_input();
        if (tx_held)
            s_valid <= 1'b0;
        tx_held = 1'b0;
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        latch_setting(idx, data);
    endtask

    task automatic cfg_release();
        cfg_valid <= 1'b0;
    endtask

    // Unused bits of each register that has them carry junk; a spare index gets a write too
    task automatic program_settings(input int kp, input int ki, input int kd,
                                    input int band, input int lim, input bit mir);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_setting(CFG_GAIN_P, {junk[CFG_DATA_W-1:GAIN_W], kp[GAIN_W-1:0]});
        write_setting(CFG_GAIN_I, {junk[CFG_DATA_W-1:GAIN_W], ki[GAIN_W-1:0]});
        write_setting(CFG_GAIN_D, {junk[CFG_DATA_W-1:GAIN_W], kd[GAIN_W-1:0]});
        write_setting(CFG_BAND,   {junk[CFG_DATA_W-1:BAND_W], band[BAND_W-1:0]});
        write_setting(CFG_LIMIT,  lim[LIM_W-1:0]);
        write_setting(CFG_MIRROR, {junk[CFG_DATA_W-1:1], mir});
        write_setting($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                      CFG_DATA_W'($urandom));
        cfg_release();
    endtask

    task automatic wait_pending_drained();
        while (pending_drives.size() != 0)
            @(posedge aclk);
    endtask

    // Reset settings: zero, band edges, bang-bang both ways, field extremes
    task automatic test_directed();
        send_period(16'sd0, 16'd0, 1'b0);
        send_period(16'sd30, 16'd0, 1'b0);
        send_period(-16'sd30, 16'd0, 1'b0);
        send_period(16'sd31, 16'd0, 1'b0);
        send_period(-16'sd31, 16'd0, 1'b0);
        send_period(16'sh7FFF, 16'd0, 1'b0);
        send_period(16'sh8000, 16'hFFFF, 1'b0);
        send_period(16'sh8000, 16'hFFFF, 1'b1);
        send_period(16'sh7FFF, 16'hFFFF, 1'b1);
        send_period(16'sd0, 16'h8000, 1'b1);
        send_period(16'sd5, 16'd5, 1'b0);
        send_period(16'sd0, 16'd0, 1'b1);
        send_period(-16'sd12, 16'd3, 1'b1);
        stop_input();
        wait_pending_drained();
    endtask

    // Register extremes, mirrored side, spare indexes and a lowered limit
    task automatic test_registers();
        program_settings(0, 0, 0, 1023, 16383, 1'b1);
        send_period(-16'sd20000, 16'd0, 1'b0);
        send_period(16'sd20000, 16'd0, 1'b0);
        send_period(-16'sd20000, 16'd0, 1'b0);
        stop_input();
        wait_pending_drained();
        write_setting(CFG_LIMIT, 14'd50);
        cfg_release();
        send_period(-16'sd20000, 16'd20000, 1'b1);
        stop_input();
        wait_pending_drained();
        program_settings(1023, 1023, 1023, 0, 0, 1'b0);
        send_period(16'sd7, 16'd7, 1'b0);
        send_period(16'sd1, 16'd0, 1'b0);
        stop_input();
        wait_pending_drained();
        program_settings(1023, 1023, 1023, 1023, 16383, 1'b0);
        send_period(16'sd100, 16'd0, 1'b0);
        send_period(-16'sd100, 16'd0, 1'b0);
        send_period(16'sd0, 16'd0, 1'b0);
        stop_input();
        wait_pending_drained();
    endtask

    // Mostly periods near the band with random content, some corners, some noise
    task automatic test_random_phase();
        int s, n, r, err, tgt, eff, spd;
        logic dir;
        logic signed [TGT_W-1:0] t;
        logic [CNT_W-1:0] c;
        for (s = 0; s < 4; s++) begin
            wait_pending_drained();
            program_settings(pick_level(1023, 1023), pick_level(1023, 1023),
                             pick_level(1023, 1023), pick_level(1023, 120),
                             pick_level(16383, 16383), 1'($urandom_range(1)));
            for (n = 0; n < 120; n++) begin
                r = $urandom_range(99);
                if (r < 70) begin
                    err = int'($urandom_range(2 * settings.error_band + 4))
                        - int'(settings.error_band) - 2;
                    tgt = int'($urandom_range(4000)) - 2000;
                    if ($urandom_range(9) == 0)
                        tgt = int'($urandom_range(60000)) - 30000;
                    eff = settings.mirror_side ? -tgt : tgt;
                    spd = eff - err;
                    if (spd < 0) begin
                        dir = 1'b1;
                        spd = -spd;
                    end else begin
                        dir = (spd == 0) ? 1'($urandom_range(1)) : 1'b0;
                    end
                    t = tgt[TGT_W-1:0];
                    c = spd[CNT_W-1:0];
                end else if (r < 82) begin
                    case ($urandom_range(4))
                        0: t = 16'sh7FFF;
                        1: t = 16'sh8000;
                        2: t = 16'sd0;
                        3: t = -16'sd1;
                        default: t = 16'sd1;
                    endcase
                    case ($urandom_range(3))
                        0: c = 16'd0;
                        1: c = 16'hFFFF;
                        2: c = 16'h8000;
                        default: c = 16'd1;
                    endcase
                    dir = 1'($urandom_range(1));
                end else begin
                    t   = TGT_W'($urandom);
                    c   = CNT_W'($urandom);
                    dir = 1'($urandom_range(1));
                end
                send_period(t, c, dir);
            end
            stop_input();
        end
        wait_pending_drained();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 34;
        rx_idle_pct = 78;
        test_directed();
        test_registers();
        test_random_phase();
        tx_idle_pct = 78;
        rx_idle_pct = 34;
        test_random_phase();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_phase();
        wait_pending_drained();
        repeat (END_SLACK) @(posedge aclk);
        if (pending_drives.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived", pending_drives.size()));
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
